// ===== design/ilst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ilst_pkg: shared types and constants for the indexed list unit
// Opcodes, status codes, stream field widths and the per-cell control bundle.
// ---------------------------------------------------------------------------
package ilst_pkg;

    // fixed field widths of the stream transactions
    localparam int OP_W       = 3;
    localparam int IDX_W      = 7;
    localparam int VAL_W      = 32;
    localparam int CNT_OUT_W  = 7;
    localparam int ST_W       = 2;
    localparam int IN_DATA_W  = 48;  // 42 bits of fields, padded to bytes
    localparam int OUT_DATA_W = 48;  // 41 bits of fields, padded to bytes

    // build defaults
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_WORD_BITS = 32;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_WRITE  = 3'd3,
        OP_READ   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // broadcast to every cell; at most one bit set per cycle
    typedef struct packed {
        logic shift_up;  // insert: cells above index take left neighbor
        logic shift_dn;  // remove: cells at/above index take right neighbor
        logic write;     // overwrite the cell at index
    } t_cell_ctl;

endpackage : ilst_pkg
`default_nettype wire

// ===== design/ilst_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ilst_cell: one storage slot of the list
// Holds one element, shifts with its neighbors and drives its word onto the
// read OR-bus when addressed.
// ---------------------------------------------------------------------------
module ilst_cell
    import ilst_pkg::*;
#(
    parameter int POS       = 0,
    parameter int CW        = 7,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [CW-1:0]        i_idx,
    input  wire logic [WORD_BITS-1:0] i_value,
    input  wire logic [WORD_BITS-1:0] i_left,
    input  wire logic [WORD_BITS-1:0] i_right,
    output logic      [WORD_BITS-1:0] o_data,
    output logic      [WORD_BITS-1:0] o_rd
);

    localparam logic [CW-1:0] MY_POS = CW'(POS);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 w_hit;
    logic                 w_above;

    assign w_hit   = (MY_POS == i_idx);
    assign w_above = (MY_POS > i_idx);

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            if (w_above) begin
                n_data = i_left;
            end else if (w_hit) begin
                n_data = i_value;
            end
        end else if (i_ctl.shift_dn) begin
            if (w_above || w_hit) begin
                n_data = i_right;
            end
        end else if (i_ctl.write && w_hit) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = w_hit ? r_data : '0;

endmodule : ilst_cell
`default_nettype wire

// ===== design/indexed_list_insert_remove_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// indexed_list_insert_remove_unit: bounded ordered list with insert/remove
// A row of CAPACITY cells holds the list; insert and remove shift all cells
// in parallel, so the cell row completes every command when it is accepted.
// ---------------------------------------------------------------------------
// Usage notes:
//  - Input stream (i_s_*): one transaction per command. tdata from bit 0:
//    operation[2:0], index[9:3], value[41:10], zero pad to bit 47.
//  - Output stream (o_m_*): exactly one transaction per command. tdata from
//    bit 0: read_value[31:0], element_count[38:32], status[40:39], pad.
//  - The result appears on o_m_tvalid in the cycle after the command
//    transaction. Throughput is one command per cycle while results are taken;
//    the cell row does the whole shift of an insert or remove in the accept cycle.
//  - The output register doubles as the skid stage: o_s_tready stays high
//    while the output is empty or being taken in the same cycle. When the
//    receiver stalls, the result holds and o_s_tready drops.
//  - Reset (i_rst_n low, synchronous) empties the list and the output
//    register. Element storage is not cleared and needs no sweep; a slot is
//    only ever read below the element count, where it has been written.
//  - Read data is the addressed cell's word, gathered by an OR across the
//    cells (only the addressed cell drives non-zero).
// ---------------------------------------------------------------------------
module indexed_list_insert_remove_unit
    import ilst_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,  // operation, index, value
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [OUT_DATA_W-1:0] o_m_tdata   // read_value, count, status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // state
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic [VAL_W-1:0]     r_rd;
    logic [VAL_W-1:0]     n_rd;
    t_status              r_status;
    t_status              n_status;

    // input field unpacking
    t_op                  w_op;
    logic [IDX_W-1:0]     w_idx_in;
    logic [VAL_W-1:0]     w_val_in;
    logic                 w_accept;

    assign w_op     = t_op'(i_s_tdata[OP_W-1:0]);
    assign w_idx_in = i_s_tdata[OP_W +: IDX_W];
    assign w_val_in = i_s_tdata[OP_W+IDX_W +: VAL_W];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // cell row wiring
    t_cell_ctl            w_ctl;
    logic [CW-1:0]        w_idx_x;
    logic [CW-1:0]        w_cnt_x;
    logic [CW-1:0]        w_cell_idx;
    logic [WORD_BITS-1:0] w_cell_val;
    logic [WORD_BITS-1:0] w_data [CAPACITY];
    logic [WORD_BITS-1:0] w_rd   [CAPACITY];
    logic [WORD_BITS-1:0] w_rd_all;
    logic                 w_full;
    logic                 w_ins_ok;
    logic                 w_in_range;

    assign w_idx_x    = CW'(w_idx_in);
    assign w_cnt_x    = CW'(r_count);
    assign w_full     = (r_count == CNT_FULL);
    assign w_ins_ok   = (w_idx_x <= w_cnt_x);
    assign w_in_range = (w_idx_x < w_cnt_x);
    // append is an insert at the tail
    assign w_cell_idx = (w_op == OP_APPEND) ? w_cnt_x : w_idx_x;
    assign w_cell_val = WORD_BITS'(w_val_in);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [WORD_BITS-1:0] w_left;
            logic [WORD_BITS-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_data[g];
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            ilst_cell #(
                .POS       (g),
                .CW        (CW),
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_idx   (w_cell_idx),
                .i_value (w_cell_val),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g]),
                .o_rd    (w_rd[g])
            );
        end
    endgenerate

    // read bus: only the addressed cell is non-zero
    always_comb begin
        w_rd_all = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_all = w_rd_all | w_rd[k];
        end
    end

    // command decode
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = '0;
        w_ctl    = '0;
        if (w_accept) begin
            unique case (w_op)
                OP_APPEND: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.shift_up = 1'b1;
                        n_count        = r_count + 1'b1;
                    end
                end
                OP_INSERT: begin
                    if (!w_ins_ok) begin
                        n_status = ST_BAD_INDEX;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.shift_up = 1'b1;
                        n_count        = r_count + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!w_in_range) begin
                        n_status = ST_BAD_INDEX;
                    end else begin
                        w_ctl.shift_dn = 1'b1;
                        n_count        = r_count - 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (!w_in_range) begin
                        n_status = ST_BAD_INDEX;
                    end else begin
                        w_ctl.write = 1'b1;
                    end
                end
                OP_READ: begin
                    if (!w_in_range) begin
                        n_status = ST_BAD_INDEX;
                    end else begin
                        n_rd = VAL_W'(w_rd_all);
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    // unused codes: no change, status ok
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd     <= n_rd;
            r_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        (OUT_DATA_W - VAL_W - CNT_OUT_W - ST_W)'(0),
        r_status,
        CNT_OUT_W'(r_count),
        r_rd
    };

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("element count above capacity");

    a_ctl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_ctl))
        else $error("more than one cell operation at once");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_count == CNT_FULL))
        else $error("full status with room left");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left elements");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_rd == '0))
        else $error("read data on a rejected command");

endmodule : indexed_list_insert_remove_unit
`default_nettype wire

// ===== test/tb_indexed_list_insert_remove_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_indexed_list_insert_remove_unit: self-checking bench for the list unit
// Streams list commands into the unit and checks every result against a
// behavioral mirror of the list. Starts with a directed pass over the edge
// cases, then runs fill, drain, mixed and clear command sequences with random
// content, while both stream sides insert random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_indexed_list_insert_remove_unit;
    import ilst_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1650;
    localparam int STUCK_LIMIT  = 4000;  // cycles without any transaction
    localparam int HOLD_AT      = 400;   // results seen before the long hold
    localparam int HOLD_CYCLES  = 800;   // length of the long receiver hold
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result
    localparam int MAX_REPORTS  = 10;

    // opcodes the unit leaves undefined; they must act as no-ops
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    // random sequence shapes
    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX,
        SEG_CLEAR
    } t_seg;

    // one expected result transaction
    typedef struct packed {
        logic [VAL_W-1:0]     read_value;
        logic [CNT_OUT_W-1:0] count;
        t_status              status;
    } t_reply;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;  // operation, index, value, pad
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;        // read_value, count, status, pad

    // result fields as the unit packs them
    wire [VAL_W-1:0]     got_value  = o_m_tdata[VAL_W-1:0];
    wire [CNT_OUT_W-1:0] got_count  = o_m_tdata[VAL_W +: CNT_OUT_W];
    wire [ST_W-1:0]      got_status = o_m_tdata[VAL_W+CNT_OUT_W +: ST_W];

    // commands waiting for the driver, and results owed by the unit
    logic [IN_DATA_W-1:0] pending_cmds[$];
    t_reply               due_replies[$];

    // mirror of the list contents, advanced at each command transaction
    logic [VAL_W-1:0] mirror_cells[CAP];
    int               mirror_count = 0;

    // element count as the command plan expects it, used to aim indexes
    int plan_count   = 0;
    int cmds_planned = 0;
    int cmds_taken   = 0;
    int replies_seen = 0;
    int fail_count   = 0;
    int mismatches   = 0;
    int stuck_cycles = 0;

    // sender and receiver pacing
    int   tx_gap    = 0;
    int   tx_calm   = 0;
    int   rx_stall  = 0;
    int   rx_calm   = 0;
    logic hold_done = 1'b0;

    indexed_list_insert_remove_unit #(
        .CAPACITY  (CAP),
        .WORD_BITS (DEF_WORD_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one command to the mirror and returns the result it owes.
    // Index is checked before fullness on insert; failed commands leave the
    // list untouched and read back zero.
    function automatic t_reply list_apply(input logic [IN_DATA_W-1:0] cmd);
        logic [OP_W-1:0]  op;
        int               idx;
        logic [VAL_W-1:0] val;
        t_reply           rep;
        op  = cmd[OP_W-1:0];
        idx = int'(cmd[OP_W +: IDX_W]);
        val = cmd[OP_W+IDX_W +: VAL_W];
        rep.read_value = '0;
        rep.status     = ST_OK;
        case (op)
            OP_APPEND: begin
                if (mirror_count >= CAP) begin
                    rep.status = ST_FULL;
                end else begin
                    mirror_cells[mirror_count] = val;
                    mirror_count++;
                end
            end
            OP_INSERT: begin
                if (idx > mirror_count) begin
                    rep.status = ST_BAD_INDEX;
                end else if (mirror_count >= CAP) begin
                    rep.status = ST_FULL;
                end else begin
                    // later elements move up one place
                    for (int i = mirror_count; i > idx; i--)
                        mirror_cells[i] = mirror_cells[i-1];
                    mirror_cells[idx] = val;
                    mirror_count++;
                end
            end
            OP_REMOVE: begin
                if (idx >= mirror_count) begin
                    rep.status = ST_BAD_INDEX;
                end else begin
                    // later elements move down one place
                    for (int i = idx; i + 1 < mirror_count; i++)
                        mirror_cells[i] = mirror_cells[i+1];
                    mirror_count--;
                end
            end
            OP_WRITE: begin
                if (idx >= mirror_count)
                    rep.status = ST_BAD_INDEX;
                else
                    mirror_cells[idx] = val;
            end
            OP_READ: begin
                if (idx >= mirror_count)
                    rep.status = ST_BAD_INDEX;
                else
                    rep.read_value = mirror_cells[idx];
            end
            OP_CLEAR: begin
                mirror_count = 0;
            end
            default: begin
                // spare codes: nothing changes
            end
        endcase
        rep.count = CNT_OUT_W'(mirror_count);
        return rep;
    endfunction

    // Queues one command and tracks the count it leaves, so that later
    // commands can be aimed at valid or boundary indexes.
    function automatic void queue_cmd(input logic [OP_W-1:0] op,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [VAL_W-1:0] val);
        pending_cmds.push_back({{(IN_DATA_W-OP_W-IDX_W-VAL_W){1'b0}}, val, idx, op});
        cmds_planned++;
        case (op)
            OP_APPEND: if (plan_count < CAP) plan_count++;
            OP_INSERT: if (idx <= plan_count && plan_count < CAP) plan_count++;
            OP_REMOVE: if (idx < plan_count) plan_count--;
            OP_CLEAR:  plan_count = 0;
            default:   ;
        endcase
    endfunction

    // index in 0..limit, leaning toward both ends
    function automatic logic [IDX_W-1:0] pick_index(input int limit);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 4)
            return IDX_W'(limit);
        return IDX_W'($urandom_range(0, limit));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 17) return OP_APPEND;
        if (r < 34) return OP_INSERT;
        if (r < 51) return OP_REMOVE;
        if (r < 68) return OP_WRITE;
        if (r < 88) return OP_READ;
        if (r < 92) return OP_CLEAR;
        if (r < 96) return OP_SPARE6;
        return OP_SPARE7;
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // -----------------------------------------------------------------------
    // Command driver: offers queued commands, holds each until taken, and
    // feeds every accepted transaction through the mirror.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                due_replies.push_back(list_apply(i_s_tdata));
                cmds_taken <= cmds_taken + 1;
            end
            // a new command may go out once the current one is gone
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    tx_gap     <= tx_gap - 1;
                end else if (pending_cmds.size() != 0) begin
                    i_s_tdata  <= pending_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    // calm stretches send back to back
                    if (tx_calm > 0)
                        tx_calm <= tx_calm - 1;
                    else if ($urandom_range(0, 99) < 2)
                        tx_calm <= $urandom_range(50, 150);
                    else
                        tx_gap <= pick_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor: checks each result transaction against the oldest
    // expectation and paces i_m_tready, including one long hold that backs
    // up the unit until it refuses commands.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                replies_seen <= replies_seen + 1;
                if (due_replies.size() == 0) begin
                    fail_count++;
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: value %h count %0d status %0d",
                                 got_value, got_count, got_status);
                    mismatches++;
                end else begin
                    want = due_replies.pop_front();
                    if (got_value !== want.read_value || got_count !== want.count
                            || got_status !== want.status) begin
                        fail_count++;
                        if (mismatches < MAX_REPORTS)
                            $display({"mismatch at result %0d: value exp %h got %h, ",
                                      "count exp %0d got %0d, status exp %0d got %0d"},
                                     replies_seen, want.read_value, got_value,
                                     want.count, got_count, want.status, got_status);
                        mismatches++;
                    end
                end
            end
            if (rx_stall > 0) begin
                i_m_tready <= 1'b0;
                rx_stall   <= rx_stall - 1;
            end else begin
                i_m_tready <= 1'b1;
                if (!hold_done && replies_seen >= HOLD_AT) begin
                    hold_done <= 1'b1;
                    rx_stall  <= HOLD_CYCLES;
                end else if (rx_calm > 0) begin
                    rx_calm <= rx_calm - 1;
                end else if ($urandom_range(0, 99) < 2) begin
                    rx_calm <= $urandom_range(50, 150);
                end else begin
                    rx_stall <= pick_gap();
                end
            end
        end
    end

    // watchdog: any transaction on either side counts as progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus plan and end of run
    // -----------------------------------------------------------------------
    initial begin
        int   r;
        int   stop_at;
        t_seg seg;

        // directed: empty list, boundaries, every opcode, clear
        queue_cmd(OP_READ,   7'd0,  32'h1111_1111);  // empty: bad index
        queue_cmd(OP_REMOVE, 7'd0,  32'h0);
        queue_cmd(OP_WRITE,  7'd0,  32'h2222_2222);
        queue_cmd(OP_INSERT, 7'd1,  32'h3333_3333);  // past the count
        queue_cmd(OP_INSERT, 7'd0,  32'h7fff_ffff);  // insert into empty list
        queue_cmd(OP_APPEND, 7'd0,  32'h8000_0000);
        queue_cmd(OP_APPEND, 7'd64, 32'hffff_ffff);  // index ignored
        queue_cmd(OP_INSERT, 7'd1,  32'h0000_0000);  // middle, shifts up
        queue_cmd(OP_INSERT, 7'd4,  32'h5a5a_5a5a);  // at count, acts as append
        queue_cmd(OP_READ,   7'd0,  32'h0);
        queue_cmd(OP_READ,   7'd4,  32'h0);
        queue_cmd(OP_READ,   7'd5,  32'h0);          // at count: bad index
        queue_cmd(OP_WRITE,  7'd2,  32'ha5a5_a5a5);  // count unchanged
        queue_cmd(OP_READ,   7'd2,  32'h0);
        queue_cmd(OP_REMOVE, 7'd0,  32'h0);          // head, shifts down
        queue_cmd(OP_REMOVE, 7'd3,  32'h0);          // tail
        queue_cmd(OP_REMOVE, 7'd3,  32'h0);          // now past the count
        queue_cmd(OP_READ,   7'd64, 32'h0);
        queue_cmd(OP_SPARE6, 7'd1,  32'hdead_beef);
        queue_cmd(OP_SPARE7, 7'd64, 32'hffff_ffff);
        queue_cmd(OP_CLEAR,  7'd5,  32'h0);
        queue_cmd(OP_READ,   7'd0,  32'h0);
        queue_cmd(OP_APPEND, 7'd0,  32'h0000_0001);
        queue_cmd(OP_READ,   7'd0,  32'h0);

        // random sequences; the first one fills the list to the brim
        stop_at = cmds_planned + RANDOM_ITEMS;
        seg     = SEG_FILL;
        while (cmds_planned < stop_at) begin
            case (seg)
                SEG_FILL: begin
                    while (plan_count < CAP) begin
                        r = $urandom_range(0, 99);
                        if (r < 55)
                            queue_cmd(OP_APPEND, IDX_W'($urandom_range(0, CAP)),
                                      pick_value());
                        else if (r < 85)
                            queue_cmd(OP_INSERT, pick_index(plan_count), pick_value());
                        else if (r < 95 && plan_count > 0)
                            queue_cmd(r[0] ? OP_READ : OP_WRITE,
                                      pick_index(plan_count - 1), pick_value());
                        else
                            queue_cmd(pick_op(), IDX_W'($urandom_range(0, CAP)),
                                      pick_value());
                    end
                    // pushing against a full list
                    repeat ($urandom_range(2, 6))
                        queue_cmd($urandom_range(0, 1) ? OP_APPEND : OP_INSERT,
                                  pick_index(CAP), pick_value());
                    queue_cmd(OP_READ, IDX_W'(CAP - 1), pick_value());
                end
                SEG_DRAIN: begin
                    while (plan_count > 0) begin
                        r = $urandom_range(0, 99);
                        if (r < 70)
                            queue_cmd(OP_REMOVE, pick_index(plan_count - 1), pick_value());
                        else if (r < 85)
                            queue_cmd(OP_READ, pick_index(plan_count - 1), pick_value());
                        else if (r < 95)
                            queue_cmd(OP_WRITE, pick_index(plan_count - 1), pick_value());
                        else
                            queue_cmd(OP_INSERT, pick_index(plan_count), pick_value());
                    end
                    // random commands against the emptied list
                    repeat ($urandom_range(1, 4))
                        queue_cmd(pick_op(), IDX_W'($urandom_range(0, CAP)),
                                  pick_value());
                end
                SEG_MIX: begin
                    repeat ($urandom_range(30, 90)) begin
                        if ($urandom_range(0, 9) < 6)
                            queue_cmd(pick_op(), pick_index(plan_count), pick_value());
                        else
                            queue_cmd(pick_op(), IDX_W'($urandom_range(0, CAP)),
                                      pick_value());
                    end
                end
                default: begin
                    queue_cmd(OP_CLEAR, IDX_W'($urandom_range(0, CAP)), pick_value());
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < 35)
                seg = SEG_FILL;
            else if (r < 65)
                seg = SEG_DRAIN;
            else if (r < 95)
                seg = SEG_MIX;
            else
                seg = SEG_CLEAR;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_taken < cmds_planned)
            @(posedge i_clk);
        while (due_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && due_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
